// File: src/chb_pkg.sv
// shared types, constants and the quarter-cosine table function for the heightmap brush
// no dependencies; used by chb_ctrl, chb_dp and the top level
package chb_pkg;

	localparam int MaxGrid  = 256;
	localparam int CosDepth = 256;
	localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
	localparam logic [23:0] HeightMax = 24'hFFFFFF;
	localparam logic [13:0] CountMax  = 14'd16383;
	localparam logic [8:0]  MapReset  = 9'd256;
	localparam logic [5:0]  MaxRadius = 6'd63;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SETUP,
		ST_POINT,
		ST_SEARCH,
		ST_GAIN,
		ST_WRITE,
		ST_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_wr;
		logic load;
		logic setup;
		logic rd_issue;
		logic pt_start;
		logic srch_step;
		logic gain;
		logic wr;
		logic advance;
		logic resp_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic win_empty;
		logic in_disc;
		logic srch_last;
		logic last_pt;
		logic out_free;
	} sts_t;

	// taylor divisors (2n+1)(2n+2)
	function automatic logic [63:0] cos_div(input int n);
		logic [63:0] d;
		unique case (n)
			0: d = 64'd2;
			1: d = 64'd12;
			2: d = 64'd30;
			3: d = 64'd56;
			4: d = 64'd90;
			5: d = 64'd132;
			default: d = 64'd182;
		endcase
		return d;
	endfunction

	// shift-subtract quotient, evaluated at elaboration only
	function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [63:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// quarter-cosine entry in q0.16, evaluated at elaboration only
	function automatic logic [15:0] cos_entry(input int k);
		logic [63:0] theta;
		logic [63:0] t2;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] c;
		theta = (64'(k) * HalfPiQ30) >> 8;
		t2    = (theta * theta) >> 30;
		term  = 64'd1 << 30;
		pos   = term;
		neg   = 64'd0;
		for (int n = 0; n < 7; n++) begin
			term = (term * t2) >> 30;
			term = long_div(term, cos_div(n));
			if ((n & 1) == 1) begin
				pos = pos + term;
			end else begin
				neg = neg + term;
			end
		end
		c = (pos > neg) ? pos - neg : 64'd0;
		c = (c + 64'd8192) >> 14;
		return (c > 64'd65535) ? 16'hFFFF : c[15:0];
	endfunction

endpackage

// File: src/chb_ctrl.sv
// controller state machine for the heightmap brush
// depends on chb_pkg; drives chb_dp through cmd_t and watches sts_t
module chb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_mode,
	output logic          s_tready,
	input  chb_pkg::sts_t sts,
	output chb_pkg::cmd_t cmd
);

	chb_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chb_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			chb_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) state_d = chb_pkg::ST_IDLE;
			end
			chb_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = s_mode ? chb_pkg::ST_READ : chb_pkg::ST_SETUP;
				end
			end
			chb_pkg::ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = chb_pkg::ST_RESP;
			end
			chb_pkg::ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = sts.win_empty ? chb_pkg::ST_RESP : chb_pkg::ST_POINT;
			end
			chb_pkg::ST_POINT: begin
				cmd.pt_start = 1'b1;
				if (sts.in_disc) begin
					state_d = chb_pkg::ST_SEARCH;
				end else begin
					cmd.advance = 1'b1;
					if (sts.last_pt) state_d = chb_pkg::ST_RESP;
				end
			end
			chb_pkg::ST_SEARCH: begin
				cmd.srch_step = 1'b1;
				if (sts.srch_last) state_d = chb_pkg::ST_GAIN;
			end
			chb_pkg::ST_GAIN: begin
				cmd.gain = 1'b1;
				state_d  = chb_pkg::ST_WRITE;
			end
			chb_pkg::ST_WRITE: begin
				cmd.wr      = 1'b1;
				cmd.advance = 1'b1;
				state_d     = sts.last_pt ? chb_pkg::ST_RESP : chb_pkg::ST_POINT;
			end
			chb_pkg::ST_RESP: begin
				if (sts.out_free) begin
					cmd.resp_load = 1'b1;
					state_d       = chb_pkg::ST_IDLE;
				end
			end
			default: state_d = chb_pkg::ST_IDLE;
		endcase
	end

endmodule

// File: src/chb_dp.sv
// datapath of the heightmap brush: height memory, window walk, cosine lookup, result register
// depends on chb_pkg; sequenced by chb_ctrl
module chb_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	input  logic [8:0]    cfg_data,
	input  logic          s_mode,
	input  logic [29:0]   s_data,
	input  logic          m_tready,
	output logic          m_tvalid,
	output logic [39:0]   m_tdata,
	input  chb_pkg::cmd_t cmd,
	output chb_pkg::sts_t sts
);

	// quarter-cosine rom
	logic [15:0] cos_rom [chb_pkg::CosDepth];
	for (genvar k = 0; k < chb_pkg::CosDepth; k++) begin : g_cos
		localparam logic [15:0] Entry = chb_pkg::cos_entry(k);
		assign cos_rom[k] = Entry;
	end

	// configuration
	logic [8:0] map_size_q;
	logic [7:0] lim;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_size_q <= chb_pkg::MapReset;
		end else if (cfg_valid) begin
			map_size_q <= cfg_data;
		end
	end

	// last column or row in use
	always_comb begin
		priority if (map_size_q < 9'd2) begin
			lim = 8'd1;
		end else if (map_size_q > 9'd256) begin
			lim = 8'd255;
		end else begin
			lim = 8'(map_size_q - 9'd1);
		end
	end

	// item capture
	logic       mode_q;
	logic [7:0] cx_q, cz_q, peak_q;
	logic [5:0] r_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= s_mode;
			cx_q   <= s_data[7:0];
			cz_q   <= s_data[15:8];
			r_q    <= (s_data[21:16] > chb_pkg::MaxRadius) ? chb_pkg::MaxRadius
			          : s_data[21:16];
			peak_q <= s_data[29:22];
		end
	end

	// window bounds clipped per axis
	logic [7:0] x0, x1, z0, z1;
	logic [8:0] x1e, z1e;
	always_comb begin
		x0  = (cx_q >= {2'b0, r_q}) ? cx_q - {2'b0, r_q} : 8'd0;
		z0  = (cz_q >= {2'b0, r_q}) ? cz_q - {2'b0, r_q} : 8'd0;
		x1e = {1'b0, cx_q} + {3'b0, r_q} - 9'd1;
		z1e = {1'b0, cz_q} + {3'b0, r_q} - 9'd1;
		x1  = (x1e > {1'b0, lim}) ? lim : x1e[7:0];
		z1  = (z1e > {1'b0, lim}) ? lim : z1e[7:0];
	end

	logic [7:0]  x0_q, x1_q, z1_q, cur_x_q, cur_z_q;
	logic [11:0] r2_q;
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			x0_q    <= x0;
			x1_q    <= x1;
			z1_q    <= z1;
			cur_x_q <= x0;
			cur_z_q <= z0;
			r2_q    <= {6'd0, r_q} * {6'd0, r_q};
		end else if (cmd.advance) begin
			if (cur_x_q == x1_q) begin
				cur_x_q <= x0_q;
				cur_z_q <= cur_z_q + 8'd1;
			end else begin
				cur_x_q <= cur_x_q + 8'd1;
			end
		end
	end

	assign sts.win_empty = (r_q == 6'd0) || (x0 > x1) || (z0 > z1);
	assign sts.last_pt   = (cur_x_q == x1_q) && (cur_z_q == z1_q);

	// squared distance of the current point
	logic [8:0]  dx, dz;
	logic [6:0]  adx, adz;
	logic [12:0] d2;
	always_comb begin
		dx  = {1'b0, cur_x_q} - {1'b0, cx_q};
		dz  = {1'b0, cur_z_q} - {1'b0, cz_q};
		adx = dx[8] ? 7'(-dx) : dx[6:0];
		adz = dz[8] ? 7'(-dz) : dz[6:0];
		d2  = {6'd0, adx} * {6'd0, adx} + {6'd0, adz} * {6'd0, adz};
	end
	assign sts.in_disc = d2 < {1'b0, r2_q};

	// table index search: largest k with (k*r)^2 <= d2 * 65536, one bit a cycle
	logic [27:0] v_q;
	logic [7:0]  k_q;
	logic [13:0] kr_q;
	logic [2:0]  bit_q;
	logic [13:0] trial_r;
	logic [27:0] trial_sq;
	assign trial_r  = kr_q + (14'(r_q) << bit_q);
	assign trial_sq = trial_r * trial_r;
	assign sts.srch_last = (bit_q == 3'd0);

	always_ff @(posedge clk) begin
		if (cmd.pt_start) begin
			v_q   <= {d2[11:0], 16'd0};
			k_q   <= 8'd0;
			kr_q  <= 14'd0;
			bit_q <= 3'd7;
		end else if (cmd.srch_step) begin
			if (trial_sq <= v_q) begin
				k_q  <= k_q | (8'd1 << bit_q);
				kr_q <= trial_r;
			end
			bit_q <= bit_q - 3'd1;
		end
	end

	// gain product
	logic [23:0] prod_s1;
	always_ff @(posedge clk) begin
		if (cmd.gain) prod_s1 <= peak_q * cos_rom[k_q];
	end

	// height memory with clearing sweep
	logic [23:0] mem [chb_pkg::MaxGrid * chb_pkg::MaxGrid];
	logic [15:0] clr_addr_q;
	logic [15:0] rd_addr;
	logic [23:0] rd_data_q;
	logic [15:0] gain;
	logic [24:0] sum;
	logic        in_map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= 16'd0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= clr_addr_q + 16'd1;
		end
	end
	assign sts.clr_last = &clr_addr_q;

	assign rd_addr = cmd.rd_issue ? {cz_q, cx_q} : {cur_z_q, cur_x_q};
	assign gain    = 16'((prod_s1 + 24'd128) >> 8);
	assign sum     = {1'b0, rd_data_q} + {9'd0, gain};

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			mem[clr_addr_q] <= 24'd0;
		end else if (cmd.wr) begin
			mem[{cur_z_q, cur_x_q}] <= sum[24] ? chb_pkg::HeightMax : sum[23:0];
		end
		if (cmd.rd_issue || cmd.gain) rd_data_q <= mem[rd_addr];
		if (cmd.rd_issue) in_map_q <= (cx_q <= lim) && (cz_q <= lim);
	end

	// hill tallies
	logic [13:0] count_q;
	logic        sat_q;
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			count_q <= 14'd0;
			sat_q   <= 1'b0;
		end else if (cmd.wr) begin
			if (count_q != chb_pkg::CountMax) count_q <= count_q + 14'd1;
			if (sum[24]) sat_q <= 1'b1;
		end
	end

	// result register
	logic        out_valid_q;
	logic [39:0] out_data_q;
	assign sts.out_free = !out_valid_q || m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.resp_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.resp_load) begin
			if (mode_q) begin
				out_data_q <= {16'd0, (in_map_q ? rd_data_q : 24'd0)};
			end else begin
				out_data_q <= {1'b0, sat_q, count_q, 24'd0};
			end
		end
	end
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// File: src/cosine_hill_heightmap_brush_unit.sv
// top level of the cosine hill heightmap brush
// depends on chb_pkg, chb_ctrl and chb_dp
//
// Keeps a 256 x 256 map of unsigned q16.8 heights. Each word on the slave
// stream is one item: tuser selects a hill (0) or a height read (1). A hill
// raises every point of the map closer than the radius to the centre by
// peak * cos(distance / radius * pi/2); a read returns one stored height.
// Every item gives exactly one word on the master stream.
// Items are handled one at a time. A read issues its memory read and then
// loads the result register. A hill walks each point of its clipped window:
// a point outside the disc is skipped, one inside goes through the one-bit-
// a-cycle search for the cosine table index, then a memory read and write.
// After reset the block sweeps all 65536 height memory words to zero and
// holds s_tready low. map_size may be written at any time on the config port.
// A finished word waits in the output register while the master side stalls;
// the next item is already accepted, but its result waits for that register.
module cosine_hill_heightmap_brush_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data,    // map_size
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,     // x_coord, z_coord, radius, peak_height, zero pad
	input  logic        s_tuser,     // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata      // height_value, touched_count, saturated, zero pad
);

	chb_pkg::cmd_t cmd;
	chb_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	chb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_mode   (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	chb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_mode    (s_tuser),
		.s_data    (s_tdata[29:0]),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// File: src/chb_checker.sv
// port-level checks for the heightmap brush, bound to the top level
// depends only on the top level's ports
module chb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// one item at a time
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while busy");

	// hill words carry no height
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[38] |-> m_tdata[23:0] == 24'd0)
		else $error("saturated flag on a read word");

	// window never exceeds 126 x 126 points
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[37:24] <= 14'd15876 && !m_tdata[39])
		else $error("touched count out of range");

endmodule

bind cosine_hill_heightmap_brush_unit chb_checker u_chb_checker (.*);
